### sv/frp_pkg.sv
// Shared types and constants for the FASTA record parser.
package frp_pkg;

  // Default accumulator width for the start and end numbers
  localparam int unsigned CoordBitsDef = 32;

  // Output queue depth
  localparam int unsigned QDepth = 4;

  // Result kinds
  localparam logic [1:0] KindName    = 2'd0;
  localparam logic [1:0] KindBase    = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // Summary status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatLenDiff  = 2'd1;
  localparam logic [1:0] StatNumError = 2'd2;

  // Header format modes
  localparam logic [1:0] FmtPlain    = 2'd0;
  localparam logic [1:0] FmtRange    = 2'd1;
  localparam logic [1:0] FmtStranded = 2'd2;

  // Register indexes
  localparam logic RegIdFormat = 1'b0;

  // Parser phases
  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhSeq    = 2'd2;

  // Header fields
  localparam logic [1:0] FldName   = 2'd0;
  localparam logic [1:0] FldStart  = 2'd1;
  localparam logic [1:0] FldEnd    = 2'd2;
  localparam logic [1:0] FldStrand = 2'd3;

  // Characters
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] CaseMask = 8'hDF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_value;
    logic [31:0] coord_start;
    logic [31:0] coord_end;
    logic [7:0]  strand_char;
    logic [31:0] seq_length;
    logic [1:0]  status;
    logic        last_of_item;
  } out_t;

endpackage

### sv/frp_core.sv
// Parser state and per-byte result generation.
module frp_core #(
  parameter int unsigned CoordBits = frp_pkg::CoordBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  frp_pkg::in_t   in_data_i,
  input  logic [1:0]     hdr_mode_i,
  output logic [1:0]     res_cnt_o,
  output frp_pkg::out_t  res0_o,
  output frp_pkg::out_t  res1_o
);

  localparam int unsigned CmpW = (CoordBits > 32) ? CoordBits : 32;

  logic [1:0]           phase_q, phase_d, mid_phase;
  logic [1:0]           field_q, field_d, mid_field;
  logic                 nl_q, nl_d, mid_nl;
  logic [CoordBits-1:0] start_q, start_d, mid_start;
  logic [CoordBits-1:0] end_q, end_d, mid_end;
  logic [3:0]           flags_q, flags_d, mid_flags;
  logic [7:0]           strand_q, strand_d, mid_strand;
  logic [31:0]          count_q, count_d, mid_count;

  logic [7:0] b;
  logic       last;
  logic       bed;
  logic       is_digit;
  logic       emit_byte;
  logic [1:0] byte_kind;
  logic [7:0] byte_char;
  logic       close;

  assign b    = in_data_i.data_byte;
  assign last = in_data_i.last_byte;
  assign bed  = (hdr_mode_i == frp_pkg::FmtRange) || (hdr_mode_i == frp_pkg::FmtStranded);
  assign is_digit = (b >= frp_pkg::ChZero) && (b <= frp_pkg::ChNine);

  // Shared decimal step: acc * 10 + digit, overflow when the top bits are set
  logic [CoordBits-1:0] dig_acc;
  logic [CoordBits+3:0] dig_sum;
  logic                 dig_ovf;
  logic [CoordBits-1:0] dig_val;

  assign dig_acc = (field_q == frp_pkg::FldEnd) ? end_q : start_q;
  assign dig_sum = {1'b0, dig_acc, 3'b000} + {3'b000, dig_acc, 1'b0}
                 + (CoordBits+4)'(b - frp_pkg::ChZero);
  assign dig_ovf = |dig_sum[CoordBits+3:CoordBits];
  assign dig_val = dig_sum[CoordBits-1:0];

  // Byte processing: next state before the end-of-stream close
  always_comb begin
    mid_phase  = phase_q;
    mid_field  = field_q;
    mid_nl     = nl_q;
    mid_start  = start_q;
    mid_end    = end_q;
    mid_flags  = flags_q;
    mid_strand = strand_q;
    mid_count  = count_q;
    emit_byte  = 1'b0;
    byte_kind  = frp_pkg::KindName;
    byte_char  = b;
    close      = 1'b0;

    if (phase_q == frp_pkg::PhFirst) begin
      mid_phase = frp_pkg::PhHeader;
    end else if (phase_q == frp_pkg::PhSeq && nl_q && b == frp_pkg::ChGt) begin
      close      = 1'b1;
      mid_phase  = frp_pkg::PhHeader;
      mid_field  = frp_pkg::FldName;
      mid_nl     = 1'b0;
      mid_start  = '0;
      mid_end    = '0;
      mid_flags  = '0;
      mid_strand = '0;
      mid_count  = '0;
    end else if (b == frp_pkg::ChNl) begin
      if (phase_q == frp_pkg::PhHeader) begin
        mid_phase = frp_pkg::PhSeq;
      end else begin
        mid_nl = 1'b1;
      end
    end else begin
      mid_nl = 1'b0;
      if (phase_q == frp_pkg::PhHeader) begin
        if (!bed) begin
          emit_byte = 1'b1;
        end else if (b == frp_pkg::ChColon) begin
          mid_field = frp_pkg::FldStart;
        end else if (b == frp_pkg::ChDash) begin
          mid_field = frp_pkg::FldEnd;
        end else if (b == frp_pkg::ChLParen) begin
          if (field_q != frp_pkg::FldStart) begin
            mid_field = frp_pkg::FldStrand;
          end
        end else if (b == frp_pkg::ChRParen) begin
          if (field_q == frp_pkg::FldStrand) begin
            mid_field = frp_pkg::FldName;
          end
        end else if (field_q == frp_pkg::FldStart) begin
          if (!flags_q[1]) begin
            if (!is_digit) begin
              mid_flags[1] = 1'b1;
            end else if (dig_ovf) begin
              mid_flags[1] = 1'b1;
              mid_flags[0] = 1'b0;
            end else begin
              mid_start    = dig_val;
              mid_flags[0] = 1'b1;
            end
          end
        end else if (field_q == frp_pkg::FldEnd) begin
          if (!flags_q[3]) begin
            if (!is_digit) begin
              mid_flags[3] = 1'b1;
            end else if (dig_ovf) begin
              mid_flags[3] = 1'b1;
              mid_flags[2] = 1'b0;
            end else begin
              mid_end      = dig_val;
              mid_flags[2] = 1'b1;
            end
          end
        end else if (field_q == frp_pkg::FldStrand) begin
          mid_strand = b;
        end else begin
          emit_byte = 1'b1;
        end
      end else begin
        // sequence base: upper-case a..z, saturating count
        emit_byte = 1'b1;
        byte_kind = frp_pkg::KindBase;
        if (b >= frp_pkg::ChLowA && b <= frp_pkg::ChLowZ) begin
          byte_char = b & frp_pkg::CaseMask;
        end
        if (count_q != '1) begin
          mid_count = count_q + 32'd1;
        end
      end
    end
  end

  // Summary unit: current record on a closing '>', else the post-byte record
  logic [CoordBits-1:0] sum_start, sum_end;
  logic [3:0]           sum_flags;
  logic [7:0]           sum_strand;
  logic [31:0]          sum_count;
  logic [CmpW-1:0]      s_ext, e_ext, diff;
  logic                 len_ok;
  frp_pkg::out_t        sum_res, empty_res, byte_res;

  assign sum_start  = close ? start_q  : mid_start;
  assign sum_end    = close ? end_q    : mid_end;
  assign sum_flags  = close ? flags_q  : mid_flags;
  assign sum_strand = close ? strand_q : mid_strand;
  assign sum_count  = close ? count_q  : mid_count;

  assign s_ext  = CmpW'(sum_start);
  assign e_ext  = CmpW'(sum_end);
  assign diff   = e_ext - s_ext;
  assign len_ok = (e_ext >= s_ext) && (diff == CmpW'(sum_count));

  always_comb begin
    sum_res              = '0;
    sum_res.kind         = frp_pkg::KindSummary;
    sum_res.seq_length   = sum_count;
    sum_res.strand_char  = frp_pkg::ChPlus;
    if (bed) begin
      sum_res.coord_start = s_ext[31:0];
      sum_res.coord_end   = e_ext[31:0];
      if (hdr_mode_i == frp_pkg::FmtStranded && sum_strand != 8'd0) begin
        sum_res.strand_char = sum_strand;
      end
      if (!sum_flags[0] || !sum_flags[2]) begin
        sum_res.status = frp_pkg::StatNumError;
      end else if (len_ok) begin
        sum_res.status = frp_pkg::StatOk;
      end else begin
        sum_res.status = frp_pkg::StatLenDiff;
      end
    end else begin
      sum_res.coord_end = sum_count;
      sum_res.status    = frp_pkg::StatOk;
    end
  end

  // Summary of the empty record that follows a closing '>' on the last byte
  always_comb begin
    empty_res             = '0;
    empty_res.kind        = frp_pkg::KindSummary;
    empty_res.strand_char = frp_pkg::ChPlus;
    empty_res.status      = bed ? frp_pkg::StatNumError : frp_pkg::StatOk;
  end

  always_comb begin
    byte_res            = '0;
    byte_res.kind       = byte_kind;
    byte_res.char_value = byte_char;
  end

  // Result assembly
  always_comb begin
    res0_o    = '0;
    res1_o    = '0;
    res_cnt_o = 2'd0;
    if (emit_byte || close) begin
      res0_o = close ? sum_res : byte_res;
      if (last) begin
        res1_o              = close ? empty_res : sum_res;
        res1_o.last_of_item = 1'b1;
        res_cnt_o           = 2'd2;
      end else begin
        res0_o.last_of_item = 1'b1;
        res_cnt_o           = 2'd1;
      end
    end else if (last) begin
      res0_o              = sum_res;
      res0_o.last_of_item = 1'b1;
      res_cnt_o           = 2'd1;
    end
  end

  // End of stream clears the record and waits for a new first byte
  always_comb begin
    phase_d  = mid_phase;
    field_d  = mid_field;
    nl_d     = mid_nl;
    start_d  = mid_start;
    end_d    = mid_end;
    flags_d  = mid_flags;
    strand_d = mid_strand;
    count_d  = mid_count;
    if (last) begin
      phase_d  = frp_pkg::PhFirst;
      field_d  = frp_pkg::FldName;
      nl_d     = 1'b0;
      start_d  = '0;
      end_d    = '0;
      flags_d  = '0;
      strand_d = '0;
      count_d  = '0;
    end
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= frp_pkg::PhFirst;
      field_q  <= frp_pkg::FldName;
      nl_q     <= 1'b0;
      start_q  <= '0;
      end_q    <= '0;
      flags_q  <= '0;
      strand_q <= '0;
      count_q  <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      field_q  <= field_d;
      nl_q     <= nl_d;
      start_q  <= start_d;
      end_q    <= end_d;
      flags_q  <= flags_d;
      strand_q <= strand_d;
      count_q  <= count_d;
    end
  end

endmodule

### sv/frp_outq.sv
// Result queue: takes up to two results per cycle, delivers one.
module frp_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  frp_pkg::out_t wr0_i,
  input  frp_pkg::out_t wr1_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output frp_pkg::out_t out_data_o
);

  localparam int unsigned PtrW = $clog2(frp_pkg::QDepth);
  localparam int unsigned CntW = $clog2(frp_pkg::QDepth + 1);

  frp_pkg::out_t mem [frp_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(frp_pkg::QDepth - 2));
  assign wr_ptr1     = wr_ptr_q + PtrW'(1);
  assign cnt_d       = cnt_q + CntW'(push_cnt_i) - CntW'(pop);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= wr0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_ptr1] <= wr1_i;
    end
  end

  // Fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(frp_pkg::QDepth))
    else $error("result queue overfilled");

  // Results are only pushed when two slots are free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("push without room");

  // A lone delivery lowers the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_cnt_i == 2'd0) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("count not decremented on delivery");

endmodule

### sv/fasta_record_parser.sv
// Top level of the FASTA record parser: register port, parser core, result queue.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one text byte per
// transfer plus a flag on the last byte of the stream. Output channel
// (out_valid_o / out_ready_i / out_data_o) carries name characters, upper-cased
// bases and per-record summaries, with last_of_item on the final result of a byte.
// The APB port holds the header mode at address 0 (plain, name:start-end,
// stranded); write it only while the parser is idle.
// A result is written into the result queue on its input transfer.
// Throughput: one byte per cycle while bytes make at most one result and the
// receiver keeps up; the results of a byte that makes two (record close plus
// end of stream) leave one at a time through the single read port of the 4-entry result queue.
// in_ready_o is high while the queue has two free slots, so input keeps flowing
// while a result waits; when the receiver stalls, bytes that make no result are
// still taken, and in_ready_o drops once more than two results wait. Reset clears
// the parser state, empties the queue and sets the header mode to plain; the next
// byte is taken as the first.
module fasta_record_parser #(
  parameter int unsigned CoordBits = frp_pkg::CoordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  frp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output frp_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [1:0]    fmt_q;
  logic          fire;
  logic [1:0]    res_cnt;
  frp_pkg::out_t res0, res1;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= frp_pkg::FmtPlain;
    end else if (psel && penable && pwrite && paddr[2] == frp_pkg::RegIdFormat) begin
      fmt_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == frp_pkg::RegIdFormat) begin
      prdata = {30'd0, fmt_q};
    end
  end

  assign fire = in_valid_i && in_ready_o;

  frp_core #(
    .CoordBits (CoordBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .in_data_i   (in_data_i),
    .hdr_mode_i  (fmt_q),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  frp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (fire ? res_cnt : 2'd0),
    .wr0_i       (res0),
    .wr1_i       (res1),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FASTA record parser: byte streams in, results checked.
module tb_top;

  localparam logic [1:0] FmtCodeThree = 2'd3;
  localparam longint unsigned CoordMax = 64'hFFFF_FFFF;

  // Tracks the parser state per accepted byte and holds the results it should emit
  class fasta_checker;
    logic [1:0] fmt;
    logic [1:0] phase;
    logic [1:0] field;
    bit after_nl;
    longint unsigned start_acc;
    longint unsigned end_acc;
    logic [3:0] flags;
    logic [7:0] strand;
    logic [31:0] bases;
    frp_pkg::out_t expected_results[$];
    int unsigned errors;
    int unsigned checked;

    function void reset_state();
      fmt = frp_pkg::FmtPlain;
      phase = frp_pkg::PhFirst;
      clear_record();
    endfunction

    function void clear_record();
      field = frp_pkg::FldName;
      after_nl = 0;
      start_acc = 0;
      end_acc = 0;
      flags = '0;
      strand = '0;
      bases = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Decimal accumulate; bit 0/2 = number has a digit, bit 1/3 = number stopped
    function longint unsigned add_digit(longint unsigned acc, int sh, logic [7:0] b);
      logic [3:0] has;
      logic [3:0] stop;
      longint unsigned d;
      has = 4'b0001 << sh;
      stop = 4'b0010 << sh;
      if ((flags & stop) != 0) return acc;
      if (b < frp_pkg::ChZero || b > frp_pkg::ChNine) begin
        flags |= stop;
        return acc;
      end
      d = 64'(b - frp_pkg::ChZero);
      if (acc > (CoordMax - d) / 10) begin
        flags |= stop;
        flags &= ~has;
        return acc;
      end
      flags |= has;
      return acc * 10 + d;
    endfunction

    function frp_pkg::out_t char_result(logic [1:0] kind, logic [7:0] ch);
      frp_pkg::out_t r;
      r = '0;
      r.kind = kind;
      r.char_value = ch;
      return r;
    endfunction

    function frp_pkg::out_t summarize();
      frp_pkg::out_t r;
      r = '0;
      r.kind = frp_pkg::KindSummary;
      r.seq_length = bases;
      r.strand_char = frp_pkg::ChPlus;
      if (fmt == frp_pkg::FmtRange || fmt == frp_pkg::FmtStranded) begin
        r.coord_start = start_acc[31:0];
        r.coord_end = end_acc[31:0];
        if (fmt == frp_pkg::FmtStranded && strand != 0) r.strand_char = strand;
        if (!flags[0] || !flags[2]) r.status = frp_pkg::StatNumError;
        else if (end_acc >= start_acc && end_acc - start_acc == 64'(bases))
          r.status = frp_pkg::StatOk;
        else r.status = frp_pkg::StatLenDiff;
      end else begin
        r.coord_end = bases;
        r.status = frp_pkg::StatOk;
      end
      return r;
    endfunction

    // Header byte in the coordinate modes; returns 1 when it is not a name char
    function bit header_consumes(logic [7:0] b);
      if (fmt != frp_pkg::FmtRange && fmt != frp_pkg::FmtStranded) return 0;
      if (b == frp_pkg::ChColon) field = frp_pkg::FldStart;
      else if (b == frp_pkg::ChDash) field = frp_pkg::FldEnd;
      else if (b == frp_pkg::ChLParen) begin
        if (field != frp_pkg::FldStart) field = frp_pkg::FldStrand;
      end else if (b == frp_pkg::ChRParen) begin
        if (field == frp_pkg::FldStrand) field = frp_pkg::FldName;
      end else if (field == frp_pkg::FldStart) start_acc = add_digit(start_acc, 0, b);
      else if (field == frp_pkg::FldEnd) end_acc = add_digit(end_acc, 2, b);
      else if (field == frp_pkg::FldStrand) strand = b;
      else return 0;
      return 1;
    endfunction

    // One accepted byte: advance the parser and queue what it emits
    function void take_byte(frp_pkg::in_t item);
      frp_pkg::out_t res[$];
      logic [7:0] b;
      logic [7:0] u;
      b = item.data_byte;
      if (phase == frp_pkg::PhFirst) begin
        phase = frp_pkg::PhHeader;
      end else if (phase == frp_pkg::PhSeq && after_nl && b == frp_pkg::ChGt) begin
        res = {res, summarize()};
        clear_record();
        phase = frp_pkg::PhHeader;
      end else if (b == frp_pkg::ChNl) begin
        if (phase == frp_pkg::PhHeader) phase = frp_pkg::PhSeq;
        else after_nl = 1;
      end else begin
        after_nl = 0;
        if (phase == frp_pkg::PhHeader) begin
          if (!header_consumes(b)) res = {res, char_result(frp_pkg::KindName, b)};
        end else begin
          if (bases != 32'hFFFF_FFFF) bases++;
          u = (b >= frp_pkg::ChLowA && b <= frp_pkg::ChLowZ) ? (b & frp_pkg::CaseMask) : b;
          res = {res, char_result(frp_pkg::KindBase, u)};
        end
      end
      if (item.last_byte) begin
        res = {res, summarize()};
        clear_record();
        phase = frp_pkg::PhFirst;
      end
      if (res.size() > 0) res[res.size() - 1].last_of_item = 1'b1;
      foreach (res[i]) expected_results = {expected_results, res[i]};
    endfunction

    task compare_field(string name, logic [31:0] g, logic [31:0] w);
      if (g !== w) report($sformatf("result %0d %s got %h want %h", checked, name, g, w));
    endtask

    task check_result(frp_pkg::out_t got);
      frp_pkg::out_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d not expected: %h", checked, got));
        checked++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", 32'(got.kind), 32'(want.kind));
      compare_field("char_value", 32'(got.char_value), 32'(want.char_value));
      compare_field("coord_start", got.coord_start, want.coord_start);
      compare_field("coord_end", got.coord_end, want.coord_end);
      compare_field("strand_char", 32'(got.strand_char), 32'(want.strand_char));
      compare_field("seq_length", got.seq_length, want.seq_length);
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("last_of_item", 32'(got.last_of_item), 32'(want.last_of_item));
      checked++;
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  frp_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  frp_pkg::out_t out_data_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  fasta_checker sb;
  logic [7:0] stream_q[$];
  int unsigned items_sent;
  bit calm;
  bit rx_hold = 1'b0;
  event long_stall;

  fasta_record_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random backpressure, none while calm, full during a long hold
  always @(negedge clk_i) begin
    if (rx_hold) out_ready_i <= 1'b0;
    else if (calm) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 11);
  end

  // Long receiver hold, counted here while the sender keeps offering bytes
  initial begin
    forever begin
      @(long_stall);
      rx_hold <= 1'b1;
      repeat (300) @(negedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Called at a falling edge; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit last);
    frp_pkg::in_t item;
    item.data_byte = b;
    item.last_byte = last;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (!calm && $urandom_range(99) < 11);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_format(input logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {frp_pkg::RegIdFormat, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.fmt = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every expected result is out and the parser has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Send the built stream, last flag on its final byte; optional format change mid-way
  task automatic send_stream(input int split);
    int n;
    n = stream_q.size();
    for (int i = 0; i < n; i++) begin
      if (i == split) begin
        settle();
        write_format(random_format());
      end
      send_byte(stream_q[i], i == n - 1);
    end
    stream_q.delete();
  endtask

  function automatic logic [1:0] random_format();
    if ($urandom_range(19) == 0) return FmtCodeThree;
    case ($urandom_range(2))
      0: return frp_pkg::FmtPlain;
      1: return frp_pkg::FmtRange;
      default: return frp_pkg::FmtStranded;
    endcase
  endfunction

  function automatic void add_byte(logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_base();
    string alphabet = "acgtnACGTNrykm";
    if ($urandom_range(99) < 4) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_name();
    string alphabet = "chrXYMabz_.|>019";
    if ($urandom_range(99) < 8) return 8'($urandom_range(255));
    return alphabet[$urandom_range(alphabet.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_strand();
    case ($urandom_range(4))
      0: return frp_pkg::ChPlus;
      1: return frp_pkg::ChDash;
      2: return 8'h00;
      3: return 8'h2E;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One record: header with optional coordinates, then wrapped sequence lines
  function automatic void push_record();
    logic [7:0] seq[$];
    int nbases;
    int shape;
    int line_len;
    longint unsigned s;
    longint unsigned e;
    nbases = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 16);
    for (int i = 0; i < nbases; i++) seq = {seq, pick_base()};
    shape = $urandom_range(99);
    s = $urandom_range(0, 9999);
    e = s + nbases;
    if (shape >= 55 && shape < 70) begin
      e = $urandom_range(0, 20000);
    end else if (shape >= 70 && shape < 78) begin
      // top of the coordinate range
      e = CoordMax;
      s = CoordMax - nbases;
    end else if (shape >= 78 && shape < 85) begin
      s = {32'($urandom), 32'($urandom)} | 64'h1_0000_0000;
    end else if (shape >= 85 && shape < 92) begin
      e = {32'($urandom), 32'($urandom)} | 64'h1_0000_0000;
    end
    add_byte(frp_pkg::ChGt);
    repeat ($urandom_range(0, 5)) add_byte(pick_name());
    if (shape < 96) begin
      add_byte(frp_pkg::ChColon);
      push_text($sformatf("%0d", s));
      if (shape < 92) begin
        add_byte(frp_pkg::ChDash);
        push_text($sformatf("%0d", e));
      end
      if ($urandom_range(1) == 1) begin
        add_byte(frp_pkg::ChLParen);
        add_byte(pick_strand());
        add_byte(frp_pkg::ChRParen);
      end
      repeat ($urandom_range(0, 1)) add_byte(pick_name());
    end
    add_byte(frp_pkg::ChNl);
    line_len = $urandom_range(1, 12);
    foreach (seq[i]) begin
      add_byte(seq[i]);
      if ((i + 1) % line_len == 0 || i == seq.size() - 1) add_byte(frp_pkg::ChNl);
    end
  endfunction

  // A stream of records, or a lone random byte; ends on a newline, a closing '>', or with its last newline dropped
  function automatic void build_stream();
    int recs;
    recs = $urandom_range(1, 4);
    if ($urandom_range(19) == 0) begin
      add_byte(8'($urandom_range(255)));
      return;
    end
    repeat (recs) push_record();
    if ($urandom_range(9) == 0) stream_q[0] = 8'($urandom_range(255));
    case ($urandom_range(2))
      0: ;
      1: add_byte(frp_pkg::ChGt);
      default: if (stream_q[$] == frp_pkg::ChNl) void'(stream_q.pop_back());
    endcase
  endfunction

  initial begin
    bit stalled;
    stalled = 0;
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Stranded header, '>' as the first base, closing '>' on the last byte
    write_format(frp_pkg::FmtStranded);
    push_text(">:1-3(x)\n>z\n>");
    send_stream(-1);
    // A lone byte that is both first and last of its stream
    add_byte(8'hFF);
    send_stream(-1);
    // Format code three parses as plain; byte extremes as name and base
    settle();
    write_format(FmtCodeThree);
    add_byte(8'h00);
    add_byte(8'hFF);
    push_text("\n");
    add_byte(8'h00);
    push_text("a\n>q");
    send_stream(-1);

    // Random streams
    settle();
    write_format(frp_pkg::FmtPlain);
    while (items_sent < 1200) begin
      calm = (items_sent >= 400 && items_sent < 700);
      if (!stalled && items_sent >= 200) begin
        stalled = 1;
        -> long_stall;
      end
      if ($urandom_range(9) < 3) begin
        settle();
        write_format(random_format());
      end
      build_stream();
      send_stream(($urandom_range(4) == 0) ? int'($urandom_range(1, stream_q.size() - 1)) : -1);
    end

    settle();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### sim.f
sv/frp_pkg.sv
sv/frp_core.sv
sv/frp_outq.sv
sv/fasta_record_parser.sv
tb/tb_top.sv
